/* rtl/cfbp_pkg.sv */
// ----------------------------------------------------------------------------
// cfbp_pkg - command frame byte parser shared definitions
// Item types, parser state, configuration set and the codes used throughout.
// ----------------------------------------------------------------------------
package cfbp_pkg;

    // Parser stages; the value is also the section reported with each byte
    typedef enum logic [2:0] {
        STG_TYPE    = 3'd0,
        STG_GS_LEN  = 3'd1,
        STG_SRC_LEN = 3'd2,
        STG_TLE_LEN = 3'd3,
        STG_GS_STR  = 3'd4,
        STG_SRC_STR = 3'd5,
        STG_TLE_STR = 3'd6,
        STG_REL     = 3'd7
    } stage_t;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [1:0] KIND_INIT    = 2'd0;
    localparam logic [1:0] KIND_INFER   = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_METRICS = 2'd3;

    localparam int NUM_CODES = 4;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_INIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_INFER   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_QUERY   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_METRICS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIMIT = 3'd4;

    localparam logic [15:0] LENGTH_LIMIT_RESET = 16'd1024;

    // Bytes in a length field and in the reliability word
    localparam logic [15:0] LEN_BYTES = 16'd2;
    localparam logic [15:0] REL_BYTES = 16'd4;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } cfbp_in_t;

    typedef struct packed {
        logic        consumed;
        logic [1:0]  parse_status;
        logic [2:0]  section;
        logic [7:0]  echo_byte;
        logic [15:0] byte_index;
        logic        string_end;
        logic [1:0]  command_kind;
        logic [15:0] field_length;
        logic [31:0] reliability_bits;
    } cfbp_out_t;

    typedef struct packed {
        stage_t      stage;
        status_t     status;
        logic [31:0] acc;
        logic [15:0] pos;
        logic [1:0]  kind;
        logic [15:0] length;
    } cfbp_state_t;

    typedef struct packed {
        logic [NUM_CODES-1:0][7:0] code;
        logic [15:0]               length_limit;
    } cfbp_cfg_t;

endpackage

/* rtl/cfbp_if.sv */
// ----------------------------------------------------------------------------
// cfbp_if - valid/ready channels of the command frame byte parser
// One interface for incoming frame bytes, one for parse results.
// ----------------------------------------------------------------------------
interface cfbp_in_if;
    logic                valid;
    logic                ready;
    cfbp_pkg::cfbp_in_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cfbp_out_if;
    logic                valid;
    logic                ready;
    cfbp_pkg::cfbp_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/cfbp_step.sv */
// ----------------------------------------------------------------------------
// cfbp_step - one parser step
// Next parser state and the result for one item, from the current state.
// ----------------------------------------------------------------------------
module cfbp_step (
    input  cfbp_pkg::cfbp_state_t st,
    input  cfbp_pkg::cfbp_cfg_t   cfg,
    input  cfbp_pkg::cfbp_in_t    item,
    output cfbp_pkg::cfbp_state_t nxt,
    output cfbp_pkg::cfbp_out_t   res
);

    logic [31:0] acc_shift;
    logic [31:0] acc_dec;
    logic [15:0] pos_inc;
    logic [15:0] new_len;
    logic [15:0] idx;
    logic        send;
    logic [31:0] rel;

    assign acc_shift = {st.acc[23:0], item.data_byte};
    assign acc_dec   = st.acc - 32'd1;
    assign pos_inc   = st.pos + 16'd1;
    assign new_len   = acc_shift[15:0];

    always_comb
    begin
        nxt  = st;
        res  = '0;
        idx  = '0;
        send = 1'b0;
        rel  = '0;

        if (item.op == cfbp_pkg::OP_RESTART)
        begin
            nxt.status = cfbp_pkg::ST_GOOD;
            nxt.stage  = cfbp_pkg::STG_TYPE;
        end
        else if (st.status != cfbp_pkg::ST_GOOD)
        begin
            res.parse_status = st.status;
        end
        else
        begin
            unique case (st.stage)
                cfbp_pkg::STG_TYPE:
                begin
                    nxt.acc    = '0;
                    nxt.pos    = '0;
                    nxt.length = '0;
                    // lowest kind wins when codes are duplicated
                    if (item.data_byte == cfg.code[cfbp_pkg::KIND_INIT])
                    begin
                        nxt.kind  = cfbp_pkg::KIND_INIT;
                        nxt.stage = cfbp_pkg::STG_TLE_LEN;
                    end
                    else if (item.data_byte == cfg.code[cfbp_pkg::KIND_INFER])
                    begin
                        nxt.kind  = cfbp_pkg::KIND_INFER;
                        nxt.stage = cfbp_pkg::STG_GS_LEN;
                    end
                    else if (item.data_byte == cfg.code[cfbp_pkg::KIND_QUERY])
                    begin
                        nxt.kind  = cfbp_pkg::KIND_QUERY;
                        nxt.stage = cfbp_pkg::STG_GS_LEN;
                    end
                    else if (item.data_byte == cfg.code[cfbp_pkg::KIND_METRICS])
                    begin
                        nxt.kind  = cfbp_pkg::KIND_METRICS;
                        nxt.stage = cfbp_pkg::STG_GS_LEN;
                    end
                    else
                    begin
                        nxt.kind   = cfbp_pkg::KIND_INIT;
                        nxt.status = cfbp_pkg::ST_ERROR;
                    end
                end
                cfbp_pkg::STG_GS_LEN, cfbp_pkg::STG_SRC_LEN, cfbp_pkg::STG_TLE_LEN:
                begin
                    if (pos_inc == cfbp_pkg::LEN_BYTES)
                    begin
                        nxt.length = new_len;
                        if (new_len == 16'd0 || new_len >= cfg.length_limit)
                            nxt.status = cfbp_pkg::ST_ERROR;
                        case (st.stage)
                            cfbp_pkg::STG_GS_LEN:  nxt.stage = cfbp_pkg::STG_GS_STR;
                            cfbp_pkg::STG_SRC_LEN: nxt.stage = cfbp_pkg::STG_SRC_STR;
                            default:               nxt.stage = cfbp_pkg::STG_TLE_STR;
                        endcase
                        // accumulator now counts the string bytes left
                        nxt.acc = {16'd0, new_len};
                        nxt.pos = '0;
                    end
                    else
                    begin
                        nxt.acc = acc_shift;
                        nxt.pos = pos_inc;
                    end
                end
                cfbp_pkg::STG_GS_STR, cfbp_pkg::STG_SRC_STR, cfbp_pkg::STG_TLE_STR:
                begin
                    idx     = st.pos;
                    nxt.pos = pos_inc;
                    nxt.acc = acc_dec;
                    if (acc_dec == 32'd0)
                    begin
                        send = 1'b1;
                        if (st.stage == cfbp_pkg::STG_TLE_STR)
                            nxt.status = cfbp_pkg::ST_DONE;
                        else if (st.stage == cfbp_pkg::STG_SRC_STR)
                        begin
                            nxt.stage = cfbp_pkg::STG_REL;
                            nxt.acc   = '0;
                            nxt.pos   = '0;
                        end
                        else if (st.kind == cfbp_pkg::KIND_INFER ||
                                 st.kind == cfbp_pkg::KIND_QUERY)
                            nxt.status = cfbp_pkg::ST_DONE;
                        else if (st.kind == cfbp_pkg::KIND_METRICS)
                        begin
                            nxt.stage = cfbp_pkg::STG_SRC_LEN;
                            nxt.acc   = '0;
                            nxt.pos   = '0;
                        end
                        else
                            nxt.status = cfbp_pkg::ST_ERROR;
                    end
                end
                default:
                begin
                    // reliability word, big-endian
                    nxt.acc = acc_shift;
                    nxt.pos = pos_inc;
                    if (pos_inc == cfbp_pkg::REL_BYTES)
                    begin
                        nxt.status = cfbp_pkg::ST_DONE;
                        rel        = acc_shift;
                    end
                end
            endcase

            res.consumed         = 1'b1;
            res.parse_status     = nxt.status;
            res.section          = st.stage;
            res.echo_byte        = item.data_byte;
            res.byte_index       = idx;
            res.string_end       = send;
            res.command_kind     = nxt.kind;
            res.field_length     = nxt.length;
            res.reliability_bits = rel;
        end
    end

endmodule

/* rtl/command_frame_byte_parser_core.sv */
// ----------------------------------------------------------------------------
// command_frame_byte_parser_core - streaming command frame parser
// Parses one command frame per restart and reports every byte as it passes.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : input items {op, data_byte}; op feeds one byte or restarts the
//            parser for the next frame.
//   result : one result item per input item, in order: consumed flag,
//            status, section, the byte with its string index and end flag,
//            decoded kind, current string length and the reliability word.
//   cfg_*  : write-only registers (type codes, length limit); write only
//            while no item is in flight.
// Timing: an item is taken into an input register, the parser step runs
//   between that register and the result register, which drives result.
//   One item per cycle is sustained while results are taken; the rate is
//   set by the parser step updating the state combinationally per item.
// Stall: while result is held, one more item is accepted into the input
//   register, then frame.ready drops until the result is taken.
// Reset: status good, stage waiting for the type byte, registers at their
//   default codes and a length limit of 1024.
// ----------------------------------------------------------------------------
module command_frame_byte_parser_core (
    input  logic                               clk,
    input  logic                               rst_n,
    cfbp_in_if.sink                            frame,
    cfbp_out_if.source                         result,
    input  logic                               cfg_we,
    input  logic [cfbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cfbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                  s1_valid_reg;
    cfbp_pkg::cfbp_in_t    s1_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    cfbp_pkg::cfbp_out_t   out_item_reg;

    cfbp_pkg::cfbp_state_t state_reg;
    cfbp_pkg::cfbp_state_t state_next;
    cfbp_pkg::cfbp_out_t   step_res;
    cfbp_pkg::cfbp_cfg_t   cfg_reg;

    logic advance;
    logic take;

    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready  = !s1_valid_reg || advance;
    assign take         = frame.valid && frame.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    cfbp_step u_step (
        .st   (state_reg),
        .cfg  (cfg_reg),
        .item (s1_item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_item_reg <= frame.payload;
        if (advance)
            out_item_reg <= step_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.stage  <= cfbp_pkg::STG_TYPE;
            state_reg.status <= cfbp_pkg::ST_GOOD;
            state_reg.acc    <= '0;
            state_reg.pos    <= '0;
            state_reg.kind   <= '0;
            state_reg.length <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code[cfbp_pkg::KIND_INIT]    <= 8'd1;
            cfg_reg.code[cfbp_pkg::KIND_INFER]   <= 8'd2;
            cfg_reg.code[cfbp_pkg::KIND_QUERY]   <= 8'd3;
            cfg_reg.code[cfbp_pkg::KIND_METRICS] <= 8'd4;
            cfg_reg.length_limit                 <= cfbp_pkg::LENGTH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cfbp_pkg::CFG_CODE_INIT:
                    cfg_reg.code[cfbp_pkg::KIND_INIT] <= cfg_data[7:0];
                cfbp_pkg::CFG_CODE_INFER:
                    cfg_reg.code[cfbp_pkg::KIND_INFER] <= cfg_data[7:0];
                cfbp_pkg::CFG_CODE_QUERY:
                    cfg_reg.code[cfbp_pkg::KIND_QUERY] <= cfg_data[7:0];
                cfbp_pkg::CFG_CODE_METRICS:
                    cfg_reg.code[cfbp_pkg::KIND_METRICS] <= cfg_data[7:0];
                cfbp_pkg::CFG_LENGTH_LIMIT:
                    cfg_reg.length_limit <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // a refused or restart item carries nothing but its status
    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.payload.consumed |->
            result.payload.section == 3'd0 && result.payload.byte_index == 16'd0 &&
            result.payload.echo_byte == 8'd0 && !result.payload.string_end)
        else $error("refused item carries payload");

    a_string_end_section: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.string_end |->
            result.payload.section == 3'(cfbp_pkg::STG_GS_STR) ||
            result.payload.section == 3'(cfbp_pkg::STG_SRC_STR) ||
            result.payload.section == 3'(cfbp_pkg::STG_TLE_STR))
        else $error("string end outside a string section");

    a_rel_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.payload.reliability_bits != 32'd0 |->
            result.payload.section == 3'(cfbp_pkg::STG_REL) &&
            result.payload.parse_status == 2'(cfbp_pkg::ST_DONE))
        else $error("reliability word outside frame completion");

    a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("pending input item lost while result stalled");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parser state changed without an item");

endmodule
